/* src/adaptive_pressure_smoother_unit_macros.svh */
// Assertion macros shared by the smoother RTL.
// APS_ASSERT_NOW checks the consequent in the same cycle as the antecedent;
// APS_ASSERT_NEXT checks it in the cycle after the antecedent. Both are silent in synthesis.
`ifndef ADAPTIVE_PRESSURE_SMOOTHER_UNIT_MACROS_SVH
`define ADAPTIVE_PRESSURE_SMOOTHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define APS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smoother assertion failed");
`define APS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smoother assertion failed");
`else
`define APS_ASSERT_NOW(lbl, ante, cons)
`define APS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/aps_pkg.sv */
`timescale 1ns / 1ps

package aps_pkg;

  // Field widths
  localparam int unsigned PressW   = 24;
  localparam int unsigned ClimbW   = 17;
  localparam int unsigned TickW    = 32;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned RateW    = 15;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Width of s*old + new, and one quotient bit per divide step
  localparam int unsigned AccW     = 32;
  localparam int unsigned DivSteps = AccW;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BYPASS      = 3'd0,
    REG_TRIG_LEVEL  = 3'd1,
    REG_SINK_RATE   = 3'd2,
    REG_TRIG_TIME   = 3'd3,
    REG_RELAX_TIME  = 3'd4,
    REG_MAX_SMOOTH  = 3'd5,
    REG_MIN_SMOOTH  = 3'd6,
    REG_INIT_SMOOTH = 3'd7
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADAPT,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the input beat
    logic mul;       // form s*old + new and the divisor
    logic div_step;  // one restoring divide step
    logic adapt;     // commit pressure and adapt the smoothing factor
    logic emit;      // load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bypass;
  } sts_t;

  localparam logic [LevelW-1:0] SmoothTop = '1;

endpackage

/* src/adaptive_pressure_smoother_unit.sv */
// Adaptive pressure smoother. Each input beat carries a pressure sample, the
// climb rate, a flying flag and a tick count; each produces exactly one result
// beat with the filtered pressure and the smoothing level after adaptation.
// Items are handled one at a time: a normal item passes through a multiply
// step, a bit-serial restoring divider that forms (s*old+new)/(s+1), an
// adaptation step and a hand-over step before its result is valid; a bypass
// item skips the divider. The input reopens the cycle after the hand-over
// while the result waits in the output register, so a new beat is taken only
// after the previous item has been handed over; the hand-over of the
// next item stalls while the previous result is still waiting. Configuration
// writes are always ready and must only be issued while the unit is idle;
// writing the initial smoothing level also loads it as the current level.
`timescale 1ns / 1ps

module adaptive_pressure_smoother_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // [23:0] pressure_sample, [40:24] climb_rate,
                                     // [72:41] tick_now, [79:73] zero
  input  logic [0:0]  s_axis_tuser,  // [0] flying
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [23:0] smoothed_pressure, [31:24] smoothing_level
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [aps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aps_pkg::CfgDataW-1:0] cfg_data_i
);

  aps_pkg::cmd_t cmd;
  aps_pkg::sts_t sts;
  logic [aps_pkg::PressW-1:0] smoothed;
  logic [aps_pkg::LevelW-1:0] level;

  assign cfg_ready_o = 1'b1;

  aps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  aps_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_valid_i),
    .cfg_idx_i           (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .pressure_sample_i   (s_axis_tdata[23:0]),
    .climb_rate_i        ($signed(s_axis_tdata[40:24])),
    .flying_i            (s_axis_tuser[0]),
    .tick_now_i          (s_axis_tdata[72:41]),
    .smoothed_pressure_o (smoothed),
    .smoothing_level_o   (level)
  );

  // Pack the result beat
  assign m_axis_tdata = {level, smoothed};

endmodule

/* src/aps_ctrl.sv */
`timescale 1ns / 1ps

`include "adaptive_pressure_smoother_unit_macros.svh"

module aps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  aps_pkg::sts_t sts_i,
  output aps_pkg::cmd_t cmd_o
);

  localparam logic [aps_pkg::StepCntW-1:0] LastStep =
    aps_pkg::StepCntW'(aps_pkg::DivSteps - 1);

  aps_pkg::ctrl_state_e state_q, state_d;
  logic [aps_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic ovalid_q, ovalid_d;
  logic slot_free;
  logic div_last;

  // State, step counter and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aps_pkg::ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign slot_free = !ovalid_q || out_ready_i;
  assign div_last  = (cnt_q == LastStep);

  // Sequence one item: capture, multiply, divide (skipped for bypass), adapt, hand over
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ovalid_d   = ovalid_q && !out_ready_i;
    case (state_q)
      aps_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = aps_pkg::ST_MUL;
        end
      end
      aps_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = sts_i.bypass ? aps_pkg::ST_ADAPT : aps_pkg::ST_DIV;
      end
      aps_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (div_last) begin
          state_d = aps_pkg::ST_ADAPT;
        end
      end
      aps_pkg::ST_ADAPT: begin
        cmd_o.adapt = 1'b1;
        state_d     = aps_pkg::ST_EMIT;
      end
      aps_pkg::ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = aps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aps_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = ovalid_q;

  // Checks
  `APS_ASSERT_NOW(a_emit_slot_free, cmd_o.emit, !ovalid_q || out_ready_i)
  `APS_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd_o))
  `APS_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == aps_pkg::ST_MUL)
  `APS_ASSERT_NEXT(a_div_ends, state_q == aps_pkg::ST_DIV && div_last, state_q == aps_pkg::ST_ADAPT)

endmodule

/* src/aps_dp.sv */
`timescale 1ns / 1ps

module aps_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aps_pkg::cmd_t                 cmd_i,
  output aps_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [aps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [aps_pkg::PressW-1:0]    pressure_sample_i,
  input  logic signed [aps_pkg::ClimbW-1:0] climb_rate_i,
  input  logic                          flying_i,
  input  logic [aps_pkg::TickW-1:0]     tick_now_i,
  output logic [aps_pkg::PressW-1:0]    smoothed_pressure_o,
  output logic [aps_pkg::LevelW-1:0]    smoothing_level_o
);

  // Configuration registers
  logic                        bypass_q;
  logic [aps_pkg::RateW-1:0]   trig_lvl_q;
  logic [aps_pkg::RateW-1:0]   sink_q;
  logic [aps_pkg::TimeW-1:0]   trig_time_q;
  logic [aps_pkg::TimeW-1:0]   relax_time_q;
  logic [aps_pkg::LevelW-1:0]  max_sm_q;
  logic [aps_pkg::LevelW-1:0]  min_sm_q;

  // Filter state
  logic [aps_pkg::PressW-1:0]  filt_q, filt_d;
  logic [aps_pkg::LevelW-1:0]  sf_q, sf_d;
  logic                        armed_q, armed_d;
  logic [aps_pkg::TickW-1:0]   mark_q, mark_d;

  // Captured beat
  logic [aps_pkg::PressW-1:0]        smp_q;
  logic signed [aps_pkg::ClimbW-1:0] climb_q;
  logic                              fly_q;
  logic [aps_pkg::TickW-1:0]         now_q;

  // Divider
  logic [aps_pkg::AccW-1:0]    acc_q;
  logic [aps_pkg::LevelW:0]    dvs_q;
  logic [aps_pkg::LevelW:0]    rem_q;
  logic [aps_pkg::LevelW+1:0]  trial;
  logic [aps_pkg::LevelW+1:0]  diff;
  logic                        take;

  // Output register
  logic [aps_pkg::PressW-1:0]  opress_q;
  logic [aps_pkg::LevelW-1:0]  olvl_q;

  assign sts_o.bypass = bypass_q;

  // Configuration writes; the initial level goes straight into the factor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q     <= 1'b0;
      trig_lvl_q   <= aps_pkg::RateW'(200);
      sink_q       <= '0;
      trig_time_q  <= aps_pkg::TimeW'(1000);
      relax_time_q <= aps_pkg::TimeW'(5000);
      max_sm_q     <= aps_pkg::LevelW'(100);
      min_sm_q     <= aps_pkg::LevelW'(1);
    end else if (cfg_we_i) begin
      case (aps_pkg::cfg_reg_e'(cfg_idx_i))
        aps_pkg::REG_BYPASS:      bypass_q     <= cfg_data_i[0];
        aps_pkg::REG_TRIG_LEVEL:  trig_lvl_q   <= cfg_data_i[aps_pkg::RateW-1:0];
        aps_pkg::REG_SINK_RATE:   sink_q       <= cfg_data_i[aps_pkg::RateW-1:0];
        aps_pkg::REG_TRIG_TIME:   trig_time_q  <= cfg_data_i[aps_pkg::TimeW-1:0];
        aps_pkg::REG_RELAX_TIME:  relax_time_q <= cfg_data_i[aps_pkg::TimeW-1:0];
        aps_pkg::REG_MAX_SMOOTH:  max_sm_q     <= cfg_data_i[aps_pkg::LevelW-1:0];
        aps_pkg::REG_MIN_SMOOTH:  min_sm_q     <= cfg_data_i[aps_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Latch the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q   <= pressure_sample_i;
      climb_q <= climb_rate_i;
      fly_q   <= flying_i;
      now_q   <= tick_now_i;
    end
  end

  // Restoring divide step: one quotient bit per cycle
  assign trial = {rem_q, acc_q[aps_pkg::AccW-1]};
  assign take  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      acc_q <= aps_pkg::AccW'(sf_q) * aps_pkg::AccW'(filt_q) + aps_pkg::AccW'(smp_q);
      dvs_q <= {1'b0, sf_q} + 1'b1;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      acc_q <= {acc_q[aps_pkg::AccW-2:0], take};
      rem_q <= take ? diff[aps_pkg::LevelW:0] : trial[aps_pkg::LevelW:0];
    end
  end

  // Adaptation of the smoothing factor, in model order
  always_comb begin
    logic signed [aps_pkg::ClimbW:0] v;
    logic signed [aps_pkg::ClimbW:0] neg_v;
    logic [aps_pkg::ClimbW-1:0]      mag;
    logic [aps_pkg::ClimbW-1:0]      lvl;
    logic                            above;
    logic                            below;
    logic                            arm_now;
    logic                            armed1;
    logic [aps_pkg::TickW-1:0]       mark1;
    logic signed [aps_pkg::TickW-1:0] d;
    logic signed [aps_pkg::TickW-1:0] tt;
    logic signed [aps_pkg::TickW-1:0] rt;
    logic                            raise;
    logic                            armed2;
    logic                            tmo;
    logic                            armed3;
    logic                            relax;

    v = $signed({climb_q[aps_pkg::ClimbW-1], climb_q});
    if (fly_q) begin
      v = v - $signed({3'b000, sink_q});
    end
    neg_v = -v;
    mag   = v[aps_pkg::ClimbW] ? neg_v[aps_pkg::ClimbW-1:0] : v[aps_pkg::ClimbW-1:0];
    lvl   = {2'b00, trig_lvl_q};
    above = mag > lvl;
    below = mag < lvl;

    arm_now = above && !armed_q;
    armed1  = armed_q || arm_now;
    mark1   = arm_now ? now_q : mark_q;
    d       = $signed(now_q - mark1);
    tt      = $signed({16'd0, trig_time_q});
    rt      = $signed({16'd0, relax_time_q});

    raise  = armed1 && below && (d < tt) && (sf_q <= max_sm_q) &&
             (sf_q != aps_pkg::SmoothTop);
    armed2 = armed1 && !raise;
    tmo    = (d > tt) && armed2;
    armed3 = armed2 && !tmo;
    sf_d   = raise ? sf_q + 1'b1 : sf_q;
    relax  = below && !armed3 && (d > rt) && (sf_d > min_sm_q);

    armed_d = armed3;
    mark_d  = (raise || tmo || relax) ? now_q : mark1;
    if (relax) begin
      sf_d = sf_d - 1'b1;
    end
    filt_d = acc_q[aps_pkg::PressW-1:0];

    // Bypass: take the sample, keep the adaptation state
    if (bypass_q) begin
      filt_d  = smp_q;
      sf_d    = sf_q;
      armed_d = armed_q;
      mark_d  = mark_q;
    end
  end

  // Commit filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      sf_q    <= aps_pkg::LevelW'(10);
      armed_q <= 1'b0;
      mark_q  <= '0;
    end else if (cfg_we_i &&
                 aps_pkg::cfg_reg_e'(cfg_idx_i) == aps_pkg::REG_INIT_SMOOTH) begin
      sf_q <= cfg_data_i[aps_pkg::LevelW-1:0];
    end else if (cmd_i.adapt) begin
      filt_q  <= filt_d;
      sf_q    <= sf_d;
      armed_q <= armed_d;
      mark_q  <= mark_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      opress_q <= filt_q;
      olvl_q   <= sf_q;
    end
  end

  assign smoothed_pressure_o = opress_q;
  assign smoothing_level_o   = olvl_q;

endmodule
